FILE: sv/ccpa_pkg.sv
`default_nettype none
package ccpa_pkg;

  localparam int IDX_W  = 4;
  localparam int CH_W   = 8;
  localparam int RGB_W  = 3 * CH_W;
  localparam int DIST_W = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 8;

  localparam logic [IDX_W-1:0]     DEFAULT_FG_RESET = IDX_W'(7);
  localparam logic [IDX_W-1:0]     DEFAULT_BG_RESET = IDX_W'(0);
  localparam logic [IDX_W-1:0]     BOLD_OFFSET      = IDX_W'(8);
  localparam logic [DIST_W-1:0]    DIST_MAX         = '1;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_FG = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BG = CFG_IDX_W'(1);

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_CONVERT = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [IDX_W-1:0]  entry_index;
    logic [RGB_W-1:0]  fg_rgb;
    logic              fg_is_default;
    logic [RGB_W-1:0]  bg_rgb;
    logic              bg_is_default;
    logic              bold_flag;
    logic              reverse_flag;
    logic [IDX_W-1:0]  fg_best;
    logic [DIST_W-1:0] fg_dist;
    logic [IDX_W-1:0]  bg_best;
    logic [DIST_W-1:0] bg_dist;
  } word_t;

  function automatic logic [2*CH_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return (2*CH_W)'(d) * (2*CH_W)'(d);
  endfunction

  function automatic logic [DIST_W-1:0] color_dist(input logic [RGB_W-1:0] a,
                                                   input logic [RGB_W-1:0] b);
    logic [DIST_W-1:0] sr;
    logic [DIST_W-1:0] sg;
    logic [DIST_W-1:0] sb;
    sr = DIST_W'(sq_diff(a[23:16], b[23:16]));
    sg = DIST_W'(sq_diff(a[15:8], b[15:8]));
    sb = DIST_W'(sq_diff(a[7:0], b[7:0]));
    return sr + sg + sb;
  endfunction

endpackage
`default_nettype wire

FILE: sv/ccpa_cell.sv
`default_nettype none
module ccpa_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic             in_valid,
  input  wire ccpa_pkg::word_t  in_word,
  output logic                  out_valid,
  output ccpa_pkg::word_t       out_word
);

  logic [ccpa_pkg::RGB_W-1:0]  entry_r;
  logic                        valid_r;
  ccpa_pkg::word_t             word_r;
  ccpa_pkg::word_t             word_nxt;
  logic [ccpa_pkg::DIST_W-1:0] fg_d;
  logic [ccpa_pkg::DIST_W-1:0] bg_d;
  logic                        hit_load;

  assign hit_load = in_valid && (in_word.mode == ccpa_pkg::MODE_LOAD) &&
                    (in_word.entry_index == ccpa_pkg::IDX_W'(CELL_INDEX));

  always_comb begin
    fg_d     = ccpa_pkg::color_dist(in_word.fg_rgb, entry_r);
    bg_d     = ccpa_pkg::color_dist(in_word.bg_rgb, entry_r);
    word_nxt = in_word;
    if (fg_d < in_word.fg_dist) begin
      word_nxt.fg_dist = fg_d;
      word_nxt.fg_best = ccpa_pkg::IDX_W'(CELL_INDEX);
    end
    if (bg_d < in_word.bg_dist) begin
      word_nxt.bg_dist = bg_d;
      word_nxt.bg_best = ccpa_pkg::IDX_W'(CELL_INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_r <= word_nxt;
      if (hit_load) begin
        entry_r <= in_word.fg_rgb;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule
`default_nettype wire

FILE: sv/ccpa_out.sv
`default_nettype none
module ccpa_out (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire ccpa_pkg::word_t                  in_word,
  input  wire logic [ccpa_pkg::IDX_W-1:0]       default_fg,
  input  wire logic [ccpa_pkg::IDX_W-1:0]       default_bg,
  output logic                                  advance,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [ccpa_pkg::OUT_DATA_W-1:0]       out_tdata
);

  logic                            valid_r;
  logic                            valid_nxt;
  logic [ccpa_pkg::OUT_DATA_W-1:0] attr_r;
  logic [ccpa_pkg::OUT_DATA_W-1:0] attr_nxt;
  logic [ccpa_pkg::IDX_W-1:0]      fg;
  logic [ccpa_pkg::IDX_W-1:0]      bg;

  assign advance = !valid_r || out_tready;

  always_comb begin
    fg = in_word.fg_is_default ? default_fg : in_word.fg_best;
    bg = in_word.bg_is_default ? default_bg : in_word.bg_best;
    if (in_word.bold_flag && !fg[ccpa_pkg::IDX_W-1]) begin
      fg = fg + ccpa_pkg::BOLD_OFFSET;
    end
    attr_nxt  = in_word.reverse_flag ? {fg, bg} : {bg, fg};
    valid_nxt = in_valid && (in_word.mode == ccpa_pkg::MODE_CONVERT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && valid_nxt) begin
      attr_r <= attr_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = attr_r;

endmodule
`default_nettype wire

FILE: sv/cell_colour_to_palette_attr.sv
// Cell colour to palette attribute converter.
// Input stream: in_tuser selects the word kind (0 loads a palette entry,
// 1 converts a colour pair). A load writes entry in_tdata[3:0] with the
// foreground RGB and gives no output word; an index beyond the palette
// is dropped. A convert gives one out_tdata attribute byte, background
// index in the high nibble, foreground in the low (reverse_flag swaps).
// The palette lives in a row of PALETTE_SIZE cells, one entry per cell.
// Each word walks the row one cell per cycle when not stalled; loads
// walk it too: each convert sees exactly the loads accepted before it.
// Path: an accepted word is registered in each cell, then in ccpa_out.
// Throughput: one word per cycle when not stalled; set by the row.
// Stall: when out_tvalid is high and out_tready low the whole row holds
// and in_tready drops.
// Reset: clears all valid flags and sets the default indices to 7 and 0;
// palette entries are undefined until loaded.
// Config: cfg_we writes register cfg_index (0 default foreground index,
// 1 default background index); write only while the block is idle.
`default_nettype none
module cell_colour_to_palette_attr #(
  parameter int PALETTE_SIZE = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // entry_index, fg_red, fg_green, fg_blue, fg_is_default, bg_red,
  // bg_green, bg_blue, bg_is_default, bold_flag, reverse_flag
  input  wire logic [ccpa_pkg::IN_DATA_W-1:0]       in_tdata,
  // mode
  input  wire logic                                 in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // attr_byte
  output logic [ccpa_pkg::OUT_DATA_W-1:0]           out_tdata,
  input  wire logic                                 cfg_we,
  input  wire logic [ccpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ccpa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic                        advance;
  logic [PALETTE_SIZE:0]       chain_valid;
  ccpa_pkg::word_t             chain_word [PALETTE_SIZE+1];
  ccpa_pkg::word_t             head_word;
  logic [ccpa_pkg::IDX_W-1:0]  default_fg_r;
  logic [ccpa_pkg::IDX_W-1:0]  default_bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_fg_r <= ccpa_pkg::DEFAULT_FG_RESET;
      default_bg_r <= ccpa_pkg::DEFAULT_BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ccpa_pkg::REG_DEFAULT_FG: default_fg_r <= cfg_data;
        ccpa_pkg::REG_DEFAULT_BG: default_bg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready      = advance;
  assign chain_valid[0] = in_tvalid && advance;

  always_comb begin
    head_word               = '0;
    head_word.mode          = ccpa_pkg::mode_t'(in_tuser);
    head_word.entry_index   = in_tdata[3:0];
    head_word.fg_rgb        = {in_tdata[11:4], in_tdata[19:12], in_tdata[27:20]};
    head_word.fg_is_default = in_tdata[28];
    head_word.bg_rgb        = {in_tdata[36:29], in_tdata[44:37], in_tdata[52:45]};
    head_word.bg_is_default = in_tdata[53];
    head_word.bold_flag     = in_tdata[54];
    head_word.reverse_flag  = in_tdata[55];
    head_word.fg_dist       = ccpa_pkg::DIST_MAX;
    head_word.bg_dist       = ccpa_pkg::DIST_MAX;
  end

  assign chain_word[0] = head_word;

  for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
    ccpa_cell #(
      .CELL_INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .in_valid  (chain_valid[i]),
      .in_word   (chain_word[i]),
      .out_valid (chain_valid[i+1]),
      .out_word  (chain_word[i+1])
    );
  end

  ccpa_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chain_valid[PALETTE_SIZE]),
    .in_word    (chain_word[PALETTE_SIZE]),
    .default_fg (default_fg_r),
    .default_bg (default_bg_r),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready && out_tvalid && !out_tready))
    else $error("input accepted while output stalled");

  a_enter_row: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> chain_valid[1])
    else $error("accepted word missing from first cell");

  a_out_from_convert: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |->
      $past(chain_valid[PALETTE_SIZE] &&
            chain_word[PALETTE_SIZE].mode == ccpa_pkg::MODE_CONVERT))
    else $error("output word without a convert at row end");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && chain_valid[PALETTE_SIZE:1] == '0))
    else $error("valid state not cleared by reset");
`endif

endmodule
`default_nettype wire
